// File: hdl/alc_pkg.sv
// Package: shared types, codes and constants of the access lockout controller.
package alc_pkg;

	localparam int TIME_W = 17;
	localparam int CNT_W  = 4;
	localparam int BEEP_W = 11;
	localparam int OP_W   = 3;
	localparam int IDX_W  = 3;
	localparam int CODE_W = 4;

	localparam logic [TIME_W-1:0] TIME_MAX = '1;
	localparam logic [BEEP_W-1:0] BEEP_MAX = '1;
	localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

	// operation codes of an input item
	localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
	localparam logic [OP_W-1:0] OP_SCAN   = 3'd1;
	localparam logic [OP_W-1:0] OP_VERIFY = 3'd2;
	localparam logic [OP_W-1:0] OP_GRANT  = 3'd3;
	localparam logic [OP_W-1:0] OP_DENY   = 3'd4;
	localparam logic [OP_W-1:0] OP_RESET  = 3'd5;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_SCAN_TIME      = 3'd0;
	localparam logic [IDX_W-1:0] REG_PROCESS_TIME   = 3'd1;
	localparam logic [IDX_W-1:0] REG_VERIFY_TIMEOUT = 3'd2;
	localparam logic [IDX_W-1:0] REG_RESULT_HOLD    = 3'd3;
	localparam logic [IDX_W-1:0] REG_LOCKOUT_TIME   = 3'd4;
	localparam logic [IDX_W-1:0] REG_ALARM_TIME     = 3'd5;
	localparam logic [IDX_W-1:0] REG_FAIL_LIMIT     = 3'd6;
	localparam logic [IDX_W-1:0] REG_LOCKOUT_LIMIT  = 3'd7;

	// register reset values
	localparam logic [TIME_W-1:0] RST_SCAN_TIME      = 17'd700;
	localparam logic [TIME_W-1:0] RST_PROCESS_TIME   = 17'd900;
	localparam logic [TIME_W-1:0] RST_VERIFY_TIMEOUT = 17'd5000;
	localparam logic [TIME_W-1:0] RST_RESULT_HOLD    = 17'd3000;
	localparam logic [TIME_W-1:0] RST_LOCKOUT_TIME   = 17'd60000;
	localparam logic [TIME_W-1:0] RST_ALARM_TIME     = 17'd30000;
	localparam logic [CNT_W-1:0]  RST_FAIL_LIMIT     = 4'd3;
	localparam logic [CNT_W-1:0]  RST_LOCKOUT_LIMIT  = 4'd2;

	// reported phase codes
	localparam logic [CODE_W-1:0] CODE_IDLE    = 4'd0;
	localparam logic [CODE_W-1:0] CODE_WAIT    = 4'd1;
	localparam logic [CODE_W-1:0] CODE_SCAN    = 4'd2;
	localparam logic [CODE_W-1:0] CODE_PROC    = 4'd3;
	localparam logic [CODE_W-1:0] CODE_VERIFY  = 4'd4;
	localparam logic [CODE_W-1:0] CODE_GRANT   = 4'd5;
	localparam logic [CODE_W-1:0] CODE_DENY    = 4'd6;
	localparam logic [CODE_W-1:0] CODE_LOCK    = 4'd7;
	localparam logic [CODE_W-1:0] CODE_ALARM   = 4'd8;

	typedef enum logic [8:0] {
		PH_IDLE   = 9'b000000001,
		PH_WAIT   = 9'b000000010,
		PH_SCAN   = 9'b000000100,
		PH_PROC   = 9'b000001000,
		PH_VERIFY = 9'b000010000,
		PH_GRANT  = 9'b000100000,
		PH_DENY   = 9'b001000000,
		PH_LOCK   = 9'b010000000,
		PH_ALARM  = 9'b100000000
	} phase_t;

	typedef struct packed {
		logic [TIME_W-1:0] scan_time;
		logic [TIME_W-1:0] process_time;
		logic [TIME_W-1:0] verify_timeout;
		logic [TIME_W-1:0] result_hold;
		logic [TIME_W-1:0] lockout_time;
		logic [TIME_W-1:0] alarm_time;
		logic [CNT_W-1:0]  fail_limit;
		logic [CNT_W-1:0]  lockout_limit;
	} cfg_t;

	typedef struct packed {
		phase_t            phase;
		logic [TIME_W-1:0] elapsed;
		logic [BEEP_W-1:0] beep_el;
		logic              armed;
		logic [CNT_W-1:0]  fail_cnt;
		logic [CNT_W-1:0]  lock_cnt;
	} state_t;

	typedef struct packed {
		logic [CODE_W-1:0] phase;
		logic [CNT_W-1:0]  fail_count;
		logic [CNT_W-1:0]  lockout_count;
		logic              scan_beep;
		logic              process_beep;
		logic              verify_out;
		logic              grant_pulse;
		logic              deny_pulse;
		logic              lockout_beep;
		logic              alarm_start;
		logic              alarm_beep;
		logic              alarm_end;
	} result_t;

	function automatic logic [CODE_W-1:0] phase_code(phase_t ph);
		logic [CODE_W-1:0] c;
		case (ph)
			PH_IDLE:   c = CODE_IDLE;
			PH_WAIT:   c = CODE_WAIT;
			PH_SCAN:   c = CODE_SCAN;
			PH_PROC:   c = CODE_PROC;
			PH_VERIFY: c = CODE_VERIFY;
			PH_GRANT:  c = CODE_GRANT;
			PH_DENY:   c = CODE_DENY;
			PH_LOCK:   c = CODE_LOCK;
			PH_ALARM:  c = CODE_ALARM;
			default:   c = CODE_IDLE;
		endcase
		return c;
	endfunction

endpackage

// File: hdl/alc_if.sv
// Interfaces: input item channel and result channel of the access lockout controller.
interface alc_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  operation;
	logic        door_locked;

	modport source (output valid, output operation, output door_locked, input ready);
	modport sink   (input valid, input operation, input door_locked, output ready);
endinterface

interface alc_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  phase;
	logic [3:0]  fail_count;
	logic [3:0]  lockout_count;
	logic        scan_beep;
	logic        process_beep;
	logic        verify_out;
	logic        grant_pulse;
	logic        deny_pulse;
	logic        lockout_beep;
	logic        alarm_start;
	logic        alarm_beep;
	logic        alarm_end;

	modport source (
		output valid, output phase, output fail_count, output lockout_count,
		output scan_beep, output process_beep, output verify_out, output grant_pulse,
		output deny_pulse, output lockout_beep, output alarm_start, output alarm_beep,
		output alarm_end, input ready
	);
	modport sink (
		input valid, input phase, input fail_count, input lockout_count,
		input scan_beep, input process_beep, input verify_out, input grant_pulse,
		input deny_pulse, input lockout_beep, input alarm_start, input alarm_beep,
		input alarm_end, output ready
	);
endinterface

// File: hdl/alc_step.sv
// Next-state and result logic for one item of the access lockout controller.
module alc_step #(
	parameter int LOCKOUT_BEEP_MS = 2000,
	parameter int ALARM_BEEP_MS   = 500
) (
	input  alc_pkg::state_t              cur,
	input  logic [alc_pkg::OP_W-1:0]     op,
	input  logic                         locked,
	input  alc_pkg::cfg_t                cfg,
	output alc_pkg::state_t              nxt,
	output alc_pkg::result_t             res
);

	localparam logic [alc_pkg::BEEP_W-1:0] LOCK_PERIOD  = alc_pkg::BEEP_W'(LOCKOUT_BEEP_MS);
	localparam logic [alc_pkg::BEEP_W-1:0] ALARM_PERIOD = alc_pkg::BEEP_W'(ALARM_BEEP_MS);

	function automatic alc_pkg::state_t enter_phase(alc_pkg::state_t s, alc_pkg::phase_t ph);
		alc_pkg::state_t r;
		r         = s;
		r.phase   = ph;
		r.elapsed = '0;
		r.beep_el = '0;
		r.armed   = (ph == alc_pkg::PH_LOCK) || (ph == alc_pkg::PH_ALARM);
		return r;
	endfunction

	function automatic alc_pkg::state_t apply_deny(alc_pkg::state_t s,
			logic [alc_pkg::CNT_W-1:0] limit);
		alc_pkg::state_t           r;
		logic [alc_pkg::CNT_W-1:0] f;
		r = s;
		f = (s.fail_cnt == alc_pkg::CNT_MAX) ? alc_pkg::CNT_MAX : s.fail_cnt + 4'd1;
		r.fail_cnt = f;
		if (f >= limit) begin
			r.lock_cnt = (s.lock_cnt == alc_pkg::CNT_MAX) ? alc_pkg::CNT_MAX
				: s.lock_cnt + 4'd1;
			r = enter_phase(r, alc_pkg::PH_LOCK);
		end else begin
			r = enter_phase(r, alc_pkg::PH_DENY);
		end
		return r;
	endfunction

	always_comb begin
		alc_pkg::state_t             t;
		alc_pkg::result_t            r;
		logic [alc_pkg::TIME_W-1:0]  el;
		logic [alc_pkg::BEEP_W-1:0]  be;
		logic [alc_pkg::BEEP_W-1:0]  period;
		logic                        fire;

		t = cur;
		r = '0;
		// saturating timers, advanced only on a tick in a timed phase
		el     = cur.elapsed + {{(alc_pkg::TIME_W-1){1'b0}}, cur.elapsed != alc_pkg::TIME_MAX};
		be     = cur.beep_el + {{(alc_pkg::BEEP_W-1){1'b0}}, cur.beep_el != alc_pkg::BEEP_MAX};
		period = (cur.phase == alc_pkg::PH_ALARM) ? ALARM_PERIOD : LOCK_PERIOD;
		fire   = cur.armed || (be >= period);

		case (op)
			alc_pkg::OP_TICK: begin
				case (cur.phase)
					alc_pkg::PH_IDLE, alc_pkg::PH_WAIT: begin
					end
					alc_pkg::PH_SCAN: begin
						t.elapsed = el;
						if (el >= cfg.scan_time) begin
							t = enter_phase(t, alc_pkg::PH_PROC);
							r.process_beep = 1'b1;
						end
					end
					alc_pkg::PH_PROC: begin
						t.elapsed = el;
						if (el >= cfg.process_time) begin
							t = enter_phase(t, alc_pkg::PH_VERIFY);
							r.verify_out = 1'b1;
						end
					end
					alc_pkg::PH_VERIFY: begin
						t.elapsed = el;
						if (el >= cfg.verify_timeout) begin
							t = apply_deny(t, cfg.fail_limit);
							r.deny_pulse = 1'b1;
						end
					end
					alc_pkg::PH_GRANT, alc_pkg::PH_DENY: begin
						t.elapsed = el;
						if (el >= cfg.result_hold)
							t = enter_phase(t, alc_pkg::PH_IDLE);
					end
					alc_pkg::PH_LOCK: begin
						t.elapsed      = el;
						t.beep_el      = fire ? '0 : be;
						t.armed        = 1'b0;
						r.lockout_beep = fire;
						if (el >= cfg.lockout_time) begin
							t.fail_cnt = '0;
							if (t.lock_cnt >= cfg.lockout_limit) begin
								t = enter_phase(t, alc_pkg::PH_ALARM);
								r.alarm_start = 1'b1;
							end else begin
								t = enter_phase(t, alc_pkg::PH_IDLE);
							end
						end
					end
					alc_pkg::PH_ALARM: begin
						t.elapsed    = el;
						t.beep_el    = fire ? '0 : be;
						t.armed      = 1'b0;
						r.alarm_beep = fire;
						if (el >= cfg.alarm_time) begin
							t.fail_cnt = '0;
							t.lock_cnt = '0;
							t = enter_phase(t, alc_pkg::PH_IDLE);
							r.alarm_end = 1'b1;
						end
					end
					default: t = enter_phase(t, alc_pkg::PH_IDLE);
				endcase
			end
			alc_pkg::OP_SCAN: begin
				if (cur.phase inside {alc_pkg::PH_IDLE, alc_pkg::PH_WAIT}) begin
					t = enter_phase(t, alc_pkg::PH_SCAN);
					r.scan_beep = 1'b1;
				end
			end
			alc_pkg::OP_VERIFY: begin
				if (locked && cur.phase == alc_pkg::PH_IDLE)
					t = enter_phase(t, alc_pkg::PH_WAIT);
			end
			alc_pkg::OP_GRANT: begin
				if (cur.phase inside {alc_pkg::PH_IDLE, alc_pkg::PH_VERIFY}) begin
					t.fail_cnt = '0;
					t.lock_cnt = '0;
					t = enter_phase(t, alc_pkg::PH_GRANT);
					r.grant_pulse = 1'b1;
				end
			end
			alc_pkg::OP_DENY: begin
				if (cur.phase == alc_pkg::PH_VERIFY) begin
					t = apply_deny(t, cfg.fail_limit);
					r.deny_pulse = 1'b1;
				end
			end
			alc_pkg::OP_RESET: begin
				t.fail_cnt = '0;
				t.lock_cnt = '0;
				t = enter_phase(t, alc_pkg::PH_IDLE);
			end
			default: begin
			end
		endcase

		r.phase         = alc_pkg::phase_code(t.phase);
		r.fail_count    = t.fail_cnt;
		r.lockout_count = t.lock_cnt;
		nxt = t;
		res = r;
	end

endmodule

// File: hdl/access_lockout_controller_unit.sv
// Top level: access lockout controller with input register, state and result register.
// Pipeline: the transfer edge loads the input register, and the state update then runs
// into the result register once the result register is free to take it.
// Throughput: one item per cycle while the result channel is not stalled; the state update is combinational.
// Reset: arst_n clears phase to idle, timers and counters to zero, the pipeline valids,
// and loads the configuration registers with their documented defaults.
module access_lockout_controller_unit #(
	parameter int LOCKOUT_BEEP_MS = 2000,
	parameter int ALARM_BEEP_MS   = 500
) (
	input  logic                          clk,
	input  logic                          arst_n,
	alc_in_if.sink                        in_ch,
	alc_out_if.source                     out_ch,
	input  logic                          cfg_wr_en,
	input  logic [alc_pkg::IDX_W-1:0]     cfg_index,
	input  logic [alc_pkg::TIME_W-1:0]    cfg_wr_data
);

	// configuration registers
	alc_pkg::cfg_t cfg_q;

	// input register stage
	logic                      valid_s1;
	logic [alc_pkg::OP_W-1:0]  op_s1;
	logic                      locked_s1;

	// architectural state and result register
	alc_pkg::state_t  st_q;
	alc_pkg::state_t  st_nxt;
	alc_pkg::result_t res_q;
	alc_pkg::result_t res_nxt;
	logic             out_valid_q;

	logic out_free;
	logic adv;

	// Advance the stage when the result register is empty or being drained this cycle;
	// take a new transfer whenever the input register is empty or advancing.
	assign out_free    = !out_valid_q || out_ch.ready;
	assign adv         = valid_s1 && out_free;
	assign in_ch.ready = !valid_s1 || adv;

	// Write configuration; counts take the low bits of the data word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scan_time      <= alc_pkg::RST_SCAN_TIME;
			cfg_q.process_time   <= alc_pkg::RST_PROCESS_TIME;
			cfg_q.verify_timeout <= alc_pkg::RST_VERIFY_TIMEOUT;
			cfg_q.result_hold    <= alc_pkg::RST_RESULT_HOLD;
			cfg_q.lockout_time   <= alc_pkg::RST_LOCKOUT_TIME;
			cfg_q.alarm_time     <= alc_pkg::RST_ALARM_TIME;
			cfg_q.fail_limit     <= alc_pkg::RST_FAIL_LIMIT;
			cfg_q.lockout_limit  <= alc_pkg::RST_LOCKOUT_LIMIT;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				alc_pkg::REG_SCAN_TIME:      cfg_q.scan_time      <= cfg_wr_data;
				alc_pkg::REG_PROCESS_TIME:   cfg_q.process_time   <= cfg_wr_data;
				alc_pkg::REG_VERIFY_TIMEOUT: cfg_q.verify_timeout <= cfg_wr_data;
				alc_pkg::REG_RESULT_HOLD:    cfg_q.result_hold    <= cfg_wr_data;
				alc_pkg::REG_LOCKOUT_TIME:   cfg_q.lockout_time   <= cfg_wr_data;
				alc_pkg::REG_ALARM_TIME:     cfg_q.alarm_time     <= cfg_wr_data;
				alc_pkg::REG_FAIL_LIMIT:
					cfg_q.fail_limit <= cfg_wr_data[alc_pkg::CNT_W-1:0];
				alc_pkg::REG_LOCKOUT_LIMIT:
					cfg_q.lockout_limit <= cfg_wr_data[alc_pkg::CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Capture the input transfer; hold while the stage is stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			op_s1     <= in_ch.operation;
			locked_s1 <= in_ch.door_locked;
		end
	end

	alc_step #(
		.LOCKOUT_BEEP_MS(LOCKOUT_BEEP_MS),
		.ALARM_BEEP_MS  (ALARM_BEEP_MS)
	) u_step (
		.cur   (st_q),
		.op    (op_s1),
		.locked(locked_s1),
		.cfg   (cfg_q),
		.nxt   (st_nxt),
		.res   (res_nxt)
	);

	// Commit the state and load the result together, so the next item sees this one's effect.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase    <= alc_pkg::PH_IDLE;
			st_q.elapsed  <= '0;
			st_q.beep_el  <= '0;
			st_q.armed    <= 1'b0;
			st_q.fail_cnt <= '0;
			st_q.lock_cnt <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (adv) begin
				st_q        <= st_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_q <= res_nxt;
	end

	// Drive the result channel straight from the result register.
	assign out_ch.valid         = out_valid_q;
	assign out_ch.phase         = res_q.phase;
	assign out_ch.fail_count    = res_q.fail_count;
	assign out_ch.lockout_count = res_q.lockout_count;
	assign out_ch.scan_beep     = res_q.scan_beep;
	assign out_ch.process_beep  = res_q.process_beep;
	assign out_ch.verify_out    = res_q.verify_out;
	assign out_ch.grant_pulse   = res_q.grant_pulse;
	assign out_ch.deny_pulse    = res_q.deny_pulse;
	assign out_ch.lockout_beep  = res_q.lockout_beep;
	assign out_ch.alarm_start   = res_q.alarm_start;
	assign out_ch.alarm_beep    = res_q.alarm_beep;
	assign out_ch.alarm_end     = res_q.alarm_end;

	// A stalled result must not let the pending item slip away.
	a_stall_keeps_item: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !out_ch.ready) |=> valid_s1)
		else $error("pending item dropped while result stalled");

	// Backpressure on the input only when the input register is occupied.
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> valid_s1)
		else $error("input stalled with empty input register");

	// A grant clears both counters.
	a_grant_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && res_nxt.grant_pulse) |=> (st_q.fail_cnt == '0 && st_q.lock_cnt == '0))
		else $error("grant left a counter set");

	// A deny lands in denied or lockout.
	a_deny_target: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && res_nxt.deny_pulse) |=>
			(st_q.phase == alc_pkg::PH_DENY || st_q.phase == alc_pkg::PH_LOCK))
		else $error("deny went to an unexpected phase");

endmodule
